[design/fqaa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqaa_pkg
// Shared widths and pipeline payload types for the arcsine angle core.
// ----------------------------------------------------------------------------
package fqaa_pkg;

	localparam int IN_W   = 32;
	localparam int MAG_W  = IN_W + 1;
	localparam int SQ_W   = 2 * IN_W;
	localparam int ROOT_W = IN_W;
	localparam int ROM_W  = 29;
	localparam int ROM_Q  = 30;

	typedef struct packed {
		logic valid;
		logic re_pos;
		logic im_neg;
		logic zero;
	} fqaa_ctl_t;

	typedef struct packed {
		fqaa_ctl_t         ctl;
		logic [SQ_W-1:0]   rad;
		logic [ROOT_W+1:0] rem;
		logic [ROOT_W-1:0] root;
		logic [MAG_W-1:0]  aim;
	} fqaa_sqrt_t;

	typedef struct packed {
		fqaa_ctl_t         ctl;
		logic              ovf;
		logic              nbit;
		logic [ROOT_W-1:0] mag;
		logic [ROOT_W-1:0] rem;
	} fqaa_div_t;

endpackage

[design/fqaa_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqaa_sqrt_cell
// One digit-pair step of the integer square root chain.
// ----------------------------------------------------------------------------
module fqaa_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  fqaa_pkg::fqaa_sqrt_t d,
	output fqaa_pkg::fqaa_sqrt_t q
);
	import fqaa_pkg::*;

	logic [ROOT_W+1:0] r2;
	logic [ROOT_W+1:0] trial;
	logic              ge;
	fqaa_ctl_t         ctl_q;
	logic [SQ_W-1:0]   rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [MAG_W-1:0]  aim_q;

	assign r2    = {d.rem[ROOT_W-1:0], d.rad[SQ_W-1 -: 2]};
	assign trial = {d.root, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= d.ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {d.rad[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? r2 - trial : r2;
			root_q <= {d.root[ROOT_W-2:0], ge};
			aim_q  <= d.aim;
		end
	end

	assign q = '{ctl: ctl_q, rad: rad_q, rem: rem_q, root: root_q, aim: aim_q};

endmodule

[design/fqaa_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqaa_div_cell
// One quotient bit of the restoring sine divider.
// ----------------------------------------------------------------------------
module fqaa_div_cell #(
	parameter int QW = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  fqaa_pkg::fqaa_div_t d,
	input  logic [QW-1:0]       quo_d,
	output fqaa_pkg::fqaa_div_t q,
	output logic [QW-1:0]       quo_q
);
	import fqaa_pkg::*;

	logic [ROOT_W:0]   r2;
	logic              ge;
	fqaa_ctl_t         ctl_q;
	logic              ovf_q;
	logic [ROOT_W-1:0] mag_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W:0]   diff;

	assign r2   = {d.rem, d.nbit};
	assign ge   = r2 >= {1'b0, d.mag};
	assign diff = r2 - {1'b0, d.mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= d.ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q <= d.ovf;
			mag_q <= d.mag;
			rem_q <= ge ? diff[ROOT_W-1:0] : r2[ROOT_W-1:0];
			quo_q <= {quo_d[QW-2:0], ge};
		end
	end

	assign q = '{ctl: ctl_q, ovf: ovf_q, nbit: 1'b0, mag: mag_q, rem: rem_q};

endmodule

[design/fqaa_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqaa_interp
// Arcsine ROM lookup, linear interpolation and quadrant mapping.
// ----------------------------------------------------------------------------
module fqaa_interp #(
	parameter int FRAC_BITS  = 20,
	parameter int INDEX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  fqaa_pkg::fqaa_div_t   d,
	input  logic [FRAC_BITS:0]    quo,
	output fqaa_pkg::fqaa_ctl_t   out_ctl,
	output logic [FRAC_BITS:0]    angle
);
	import fqaa_pkg::*;

	localparam int F          = FRAC_BITS;
	localparam int IW         = INDEX_BITS + 1;
	localparam int LOW        = FRAC_BITS - INDEX_BITS;
	localparam int TABLE_LAST = 1 << INDEX_BITS;
	localparam int TABLE_SIZE = TABLE_LAST + 1;
	localparam int PW         = ROM_W + FRAC_BITS;
	localparam real PI        = 3.14159265358979323846;
	localparam real STEP      = 1.0 / TABLE_LAST;
	localparam real SCALE     = (2.0 ** ROM_Q) / (2.0 * PI);
	localparam logic [F:0]  ONE_TURN  = {1'b1, {F{1'b0}}};
	localparam logic [F:0]  HALF_TURN = {2'b01, {(F-1){1'b0}}};
	localparam logic [IW-1:0] LAST_IDX = {1'b1, {INDEX_BITS{1'b0}}};

	typedef logic [ROM_W-1:0] rom_t [TABLE_SIZE];

	function automatic rom_t build_rom();
		rom_t r;
		real  x;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			x    = real'(i) * STEP;
			r[i] = ROM_W'(longint'($floor($asin(x) * SCALE + 0.5)));
		end
		r[TABLE_LAST] = ROM_W'(1) << (ROM_Q - 2);
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	fqaa_ctl_t       ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [IW-1:0]   idx_s1;
	logic [F-1:0]    frac_s1, frac_s2;
	logic [ROM_W-1:0] y1_s2, y2_s2;
	logic [PW-1:0]   prod_s3;
	logic [F:0]      base_s3;
	logic [F:0]      angle_s4;
	logic [F:0]      s_clamp;
	logic [IW-1:0]   nxt;
	logic [ROM_W-1:0] diff;
	logic [F:0]      theta;
	logic [F:0]      angle_d;

	assign s_clamp = (d.ovf || quo > ONE_TURN) ? ONE_TURN : quo;
	assign nxt     = (idx_s1 == LAST_IDX) ? idx_s1 : idx_s1 + IW'(1);
	assign diff    = y2_s2 - y1_s2;
	assign theta   = base_s3 + (F+1)'(prod_s3[PW-1:ROM_Q]);

	always_comb begin
		case ({ctl_s3.im_neg, ctl_s3.re_pos})
			2'b01:   angle_d = theta;
			2'b00:   angle_d = HALF_TURN - theta;
			2'b11:   angle_d = ONE_TURN - theta;
			default: angle_d = HALF_TURN + theta;
		endcase
		if (ctl_s3.zero) begin
			angle_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= d.ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= IW'(s_clamp >> LOW);
			frac_s1  <= F'(s_clamp << INDEX_BITS);
			y1_s2    <= ROM[idx_s1];
			y2_s2    <= ROM[nxt];
			frac_s2  <= frac_s1;
			prod_s3  <= PW'(diff) * PW'(frac_s2);
			base_s3  <= (F+1)'(y1_s2 >> (ROM_Q - F));
			angle_s4 <= angle_d;
		end
	end

	assign out_ctl = ctl_s4;
	assign angle   = angle_s4;

endmodule

[design/four_quadrant_angle_from_arcsine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_quadrant_angle_from_arcsine_core
// Vector angle in turns: magnitude, sine, arcsine ROM, quadrant fold.
// Pipeline: input registers, the 32-cell root chain, a divider set-up register,
// the FRAC_BITS+1 cell divider chain and the interpolation stages.
// Throughput: one transfer per cycle; the whole pipe stalls only on out_ready.
// Reset clears all valid bits; the ROM is constant.
// ----------------------------------------------------------------------------
module four_quadrant_angle_from_arcsine_core #(
	parameter int FRAC_BITS  = 20,
	parameter int INDEX_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [fqaa_pkg::IN_W-1:0] real_part,
	input  logic signed [fqaa_pkg::IN_W-1:0] imag_part,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [FRAC_BITS:0]               angle_turns,
	output logic                             zero_magnitude
);
	import fqaa_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam logic [IN_W-1:0]  MIN_VAL = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] MIN_ABS = {1'b1, {IN_W{1'b0}}};

	logic              en;
	fqaa_ctl_t         ctl_s1, ctl_s2, ctl_s3, out_ctl;
	logic [MAG_W-1:0]  are_s1, aim_s1, aim_s2, aim_s3;
	logic [SQ_W-1:0]   sqre_s2, sqim_s2, sum_s3;
	logic [2*MAG_W-1:0] pre, pim;
	fqaa_sqrt_t        sqrt_c [ROOT_W+1];
	fqaa_div_t         div_c [QW+1];
	logic [QW-1:0]     quo_c [QW+1];
	fqaa_ctl_t         ctl_s4;
	logic              ovf_s4;
	logic [ROOT_W-1:0] mag_s4, rem_s4;
	logic              nbit_s4;
	logic [ROOT_W-1:0] mag_d;
	logic [MAG_W-1:0]  are_d, aim_d;

	assign en       = !out_ctl.valid || out_ready;
	assign in_ready = en;

	always_comb begin
		if (real_part[IN_W-1]) begin
			are_d = (real_part == MIN_VAL) ? MIN_ABS : {1'b0, -real_part};
		end else begin
			are_d = {1'b0, real_part};
		end
		if (imag_part[IN_W-1]) begin
			aim_d = (imag_part == MIN_VAL) ? MIN_ABS : {1'b0, -imag_part};
		end else begin
			aim_d = {1'b0, imag_part};
		end
	end

	assign pre = are_s1 * are_s1;
	assign pim = aim_s1 * aim_s1;
	assign mag_d = (sqrt_c[ROOT_W].root == '0) ? ROOT_W'(1) : sqrt_c[ROOT_W].root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid,
			            re_pos: (real_part != '0) && !real_part[IN_W-1],
			            im_neg: imag_part[IN_W-1],
			            zero: (real_part == '0) && (imag_part == '0)};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= sqrt_c[ROOT_W].ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			are_s1  <= are_d;
			aim_s1  <= aim_d;
			sqre_s2 <= pre[SQ_W-1:0];
			sqim_s2 <= pim[SQ_W-1:0];
			aim_s2  <= aim_s1;
			sum_s3  <= sqre_s2 + sqim_s2;
			aim_s3  <= aim_s2;
			mag_s4  <= mag_d;
			ovf_s4  <= sqrt_c[ROOT_W].aim >= {mag_d, 1'b0};
			rem_s4  <= sqrt_c[ROOT_W].aim[MAG_W-1:1];
			nbit_s4 <= sqrt_c[ROOT_W].aim[0];
		end
	end

	assign sqrt_c[0] = '{ctl: ctl_s3, rad: sum_s3, rem: '0, root: '0, aim: aim_s3};

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		fqaa_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (sqrt_c[i]),
			.q      (sqrt_c[i+1])
		);
	end

	assign div_c[0] = '{ctl: ctl_s4, ovf: ovf_s4, nbit: nbit_s4, mag: mag_s4, rem: rem_s4};
	assign quo_c[0] = '0;

	for (genvar j = 0; j < QW; j++) begin : g_div
		fqaa_div_cell #(.QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (div_c[j]),
			.quo_d  (quo_c[j]),
			.q      (div_c[j+1]),
			.quo_q  (quo_c[j+1])
		);
	end

	fqaa_interp #(
		.FRAC_BITS  (FRAC_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.d       (div_c[QW]),
		.quo     (quo_c[QW]),
		.out_ctl (out_ctl),
		.angle   (angle_turns)
	);

	assign out_valid      = out_ctl.valid;
	assign zero_magnitude = out_ctl.zero;

endmodule

[dv/four_quadrant_angle_from_arcsine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_quadrant_angle_from_arcsine_core_tb
// Self-checking bench for the arcsine angle core. It runs directed corner
// vectors, then random vectors over all four quadrants, several magnitude
// ranges and the axes. Both handshakes idle at random. The expected angle
// is computed from its own copy of the arcsine ROM and the integer sqrt/divide.
// ----------------------------------------------------------------------------
module four_quadrant_angle_from_arcsine_core_tb;

	localparam int FRAC  = 20;
	localparam int IDX   = 10;
	localparam int LAST  = 1 << IDX;
	localparam int LOWB  = FRAC - IDX;
	localparam int WATCHDOG = 4000;
	localparam int N_RANDOM = 1200;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
	} vec_t;

	typedef struct {
		logic [FRAC:0] angle;
		logic          zero;
	} angle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [fqaa_pkg::IN_W-1:0] real_part = '0;
	logic signed [fqaa_pkg::IN_W-1:0] imag_part = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [FRAC:0] angle_turns;
	logic zero_magnitude;

	logic [63:0] asin_rom [0:LAST];
	vec_t   vec_queue[$];
	angle_t angle_queue[$];
	int     n_err = 0;
	int     n_sent = 0;
	int     n_checked = 0;
	int     n_zero = 0;
	int     quad_hits [4] = '{0, 0, 0, 0};
	int     send_gap = 0;
	int     recv_gap = 0;
	int     idle_cycles = 0;
	bit     burst_mode = 0;

	always #6 clk = ~clk;

	four_quadrant_angle_from_arcsine_core #(.FRAC_BITS(FRAC), .INDEX_BITS(IDX)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.real_part(real_part), .imag_part(imag_part),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle_turns(angle_turns), .zero_magnitude(zero_magnitude)
	);

	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return p[125:62];
	endfunction

	// sine in Q62 of u * 2^-31 turn
	function automatic logic [63:0] sine_q62(logic [63:0] u);
		logic [63:0] x, x2, term, sum, k;
		x = ((64'h6487ED51 * u) << 3) + ((64'h10B4611A * u) >> 29);
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		k = 1;
		while (term != 0 && k < 40) begin
			term = mul_q62(term, x2) / ((2 * k) * (2 * k + 1));
			if (k[0]) sum = sum - term;
			else sum = sum + term;
			k++;
		end
		return sum;
	endfunction

	function automatic void fill_asin_rom();
		logic [63:0] target, lo, hi, mid;
		asin_rom[0] = 0;
		asin_rom[LAST] = 64'd1 << 28;
		for (int i = 1; i < LAST; i++) begin
			target = 64'(i) << (62 - IDX);
			lo = 0;
			hi = 64'd1 << 28;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (sine_q62(2 * mid - 1) <= target) lo = mid;
				else hi = mid - 1;
			end
			asin_rom[i] = lo;
		end
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// magnitude of a 32-bit two's complement value; the most negative code maps to 2^32
	function automatic logic [63:0] abs_wide(logic [31:0] v);
		logic [63:0] n;
		if (!v[31]) return {32'd0, v};
		n = {32'd0, (~v) + 32'd1};
		if (v == 32'h8000_0000) n = n + 64'h8000_0000;
		return n;
	endfunction

	function automatic angle_t vector_angle(vec_t v);
		angle_t r;
		logic [63:0] are, aim, mag, s, idx, frac, y1, y2, theta, ang;
		logic re_pos, im_neg;
		re_pos = (v.re != 0) && !v.re[31];
		im_neg = v.im[31];
		if (v.re == 0 && v.im == 0) begin
			r.angle = '0;
			r.zero = 1'b1;
			return r;
		end
		are = abs_wide(v.re);
		aim = abs_wide(v.im);
		mag = isqrt(are * are + aim * aim);
		if (mag == 0) mag = 1;
		s = (aim << FRAC) / mag;
		if (s > (64'd1 << FRAC)) s = 64'd1 << FRAC;
		idx = s >> LOWB;
		frac = (s & ((64'd1 << LOWB) - 1)) << IDX;
		if (idx > LAST) idx = LAST;
		y1 = asin_rom[idx];
		y2 = (idx < LAST) ? asin_rom[idx + 1] : y1;
		if (y2 < y1) y2 = y1;
		theta = (y1 >> (30 - FRAC)) + (((y2 - y1) * frac) >> 30);
		if (!im_neg) ang = re_pos ? theta : (64'd1 << (FRAC - 1)) - theta;
		else ang = re_pos ? (64'd1 << FRAC) - theta : (64'd1 << (FRAC - 1)) + theta;
		r.angle = ang[FRAC:0];
		r.zero = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] rand_comp(int kind);
		logic [31:0] v;
		case (kind)
			0: v = $urandom();
			1: v = $urandom_range(0, 4095);
			2: v = $urandom_range(0, 1 << 24);
			3: v = 32'h7FFF_FFFF - $urandom_range(0, 255);
			default: v = 32'h8000_0000 + $urandom_range(0, 255);
		endcase
		if (kind >= 1 && kind <= 3 && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	task automatic add_vec(logic [31:0] re, logic [31:0] im);
		vec_t v;
		v.re = re;
		v.im = im;
		vec_queue.push_back(v);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		vec_t v;
		angle_t e;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				v.re = real_part;
				v.im = imag_part;
				e = vector_angle(v);
				angle_queue.push_back(e);
				n_sent++;
				if (e.zero) n_zero++;
				else quad_hits[{v.im[31], !((v.re != 0) && !v.re[31])}]++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (vec_queue.size() > 0) begin
					v = vec_queue.pop_front();
					real_part <= v.re;
					imag_part <= v.im;
					in_valid <= 1'b1;
					send_gap <= burst_mode ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		angle_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (angle_queue.size() == 0) begin
					$display("%0t: unexpected transfer angle=%0d zero=%0b", $time,
						angle_turns, zero_magnitude);
					n_err++;
				end else begin
					e = angle_queue.pop_front();
					if (angle_turns !== e.angle) begin
						$display("%0t: angle_turns expected %0d actual %0d", $time,
							e.angle, angle_turns);
						n_err++;
					end
					if (zero_magnitude !== e.zero) begin
						$display("%0t: zero_magnitude expected %0b actual %0b", $time,
							e.zero, zero_magnitude);
						n_err++;
					end
				end
				recv_gap <= burst_mode ? 0 : $urandom_range(0, 3);
				out_ready <= burst_mode;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		fill_asin_rom();
		// corners
		add_vec(0, 0);
		add_vec(1, 0);
		add_vec(0, 1);
		add_vec(32'hFFFF_FFFF, 0);
		add_vec(0, 32'hFFFF_FFFF);
		add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_vec(32'h8000_0000, 32'h8000_0000);
		add_vec(32'h8000_0000, 0);
		add_vec(0, 32'h8000_0000);
		add_vec(32'h7FFF_FFFF, 32'h8000_0000);
		add_vec(32'h8000_0000, 32'h7FFF_FFFF);
		add_vec(0, 32'h7FFF_FFFF);
		add_vec(0, 32'h0010_0000);
		add_vec(32'h0010_0000, 32'h0010_0000);
		add_vec(32'hFFF0_0000, 32'h0010_0000);
		add_vec(32'hFFF0_0000, 32'hFFF0_0000);
		add_vec(32'h0010_0000, 32'hFFF0_0000);
		add_vec(32'h0010_0000, 32'hFFFF_FFFF);
		add_vec(1, 32'hFFFF_FFFF);
		add_vec(32'h7FFF_FFFF, 1);
		add_vec(1, 32'h7FFF_FFFF);
		add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_vec(3, 4);
		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 9))
				0: add_vec(0, rand_comp($urandom_range(0, 4)));
				1: add_vec(rand_comp($urandom_range(0, 4)), 0);
				2, 3: add_vec(rand_comp($urandom_range(0, 4)), rand_comp($urandom_range(0, 4)));
				default: add_vec(rand_comp(0), rand_comp(0));
			endcase
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (vec_queue.size() > 0 || in_valid) begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) burst_mode = !burst_mode;
		end
		burst_mode = 0;
		while (angle_queue.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("vectors sent %0d, results checked %0d, zero vectors %0d", n_sent,
			n_checked, n_zero);
		$display("quadrant hits: %0d %0d %0d %0d, mismatches %0d", quad_hits[0],
			quad_hits[1], quad_hits[2], quad_hits[3], n_err);
		if (n_err == 0 && angle_queue.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
